// File: rtl/hesd_pkg.sv
// Shared constants, types and name table for the HTML entity stream decoder.
package hesd_pkg;

    localparam int ENTITY_WINDOW_DEF = 16;
    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_1B_MAX = 21'h00007F;
    localparam logic [CP_W-1:0] CP_2B_MAX = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_3B_MAX = 21'h00FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int NAME_COUNT = 6;
    localparam logic [2:0] NM_LT = 3'd0;
    localparam logic [2:0] NM_GT = 3'd1;
    localparam logic [2:0] NM_AMP = 3'd2;
    localparam logic [2:0] NM_QUOT = 3'd3;
    localparam logic [2:0] NM_APOS = 3'd4;
    localparam logic [2:0] NM_NBSP = 3'd5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } hesd_state_t;

    function automatic logic [2:0] name_size(input logic [2:0] k);
        logic [2:0] len;
        case (k)
            NM_LT:   len = 3'd2;
            NM_GT:   len = 3'd2;
            NM_AMP:  len = 3'd3;
            NM_QUOT: len = 3'd4;
            NM_APOS: len = 3'd4;
            NM_NBSP: len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [31:0] name_text(input logic [2:0] k);
        logic [31:0] txt;
        // characters from the lowest byte up
        case (k)
            NM_LT:   txt = 32'h0000_746C;
            NM_GT:   txt = 32'h0000_7467;
            NM_AMP:  txt = 32'h0070_6D61;
            NM_QUOT: txt = 32'h746F_7571;
            NM_APOS: txt = 32'h736F_7061;
            NM_NBSP: txt = 32'h7073_626E;
            default: txt = 32'h0000_0000;
        endcase
        return txt;
    endfunction

    function automatic logic [7:0] name_char(input logic [2:0] k, input logic [1:0] i);
        logic [31:0] txt;
        txt = name_text(k);
        return txt[8*i +: 8];
    endfunction

    function automatic logic [7:0] name_value(input logic [2:0] k);
        logic [7:0] v;
        case (k)
            NM_LT:   v = CH_LT;
            NM_GT:   v = CH_GT;
            NM_AMP:  v = CH_AMP;
            NM_QUOT: v = CH_QUOT;
            NM_APOS: v = CH_APOS;
            NM_NBSP: v = CH_SPACE;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/html_entity_stream_decoder_core.sv
// Top level of the HTML entity stream decoder: sequencer, held-body RAM and output register.
//
// Usage: text bytes enter on the s_axis item channel, decoded bytes leave on m_axis.
// s_axis_tlast marks the final byte of a string; m_axis_tlast marks the final decoded
// byte produced for it. An item is taken when tvalid and tready are both high.
// Plain text bytes and body bytes after '&' are taken one per cycle while the output
// register is free or being drained; a plain byte appears on m_axis the next cycle.
// Body bytes are written into a small RAM and pass through the shared digit unit and
// the name matcher as they arrive, so ';' needs no evaluation pass.
// When an item ends an entity (';', a delimiter, a full body or the string end) the
// sequencer emits its bytes one per cycle while the output slot is free: 1..4 for a
// decoded entity, or '&', the held body (read from the RAM port one byte a cycle) and,
// unless the string ends inside the body or an '&' opens a new entity, the ending byte
// for a rejected one. s_axis_tready is low for those cycles.
// A stall on m_axis holds the output register and the sequencer position.
// Reset clears the entity flag, the held count, the sequencer and the output valid;
// the held-body RAM needs no clearing since only written entries are read.
module html_entity_stream_decoder_core #(
    parameter int ENTITY_WINDOW = hesd_pkg::ENTITY_WINDOW_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // out_last
);
    import hesd_pkg::*;

    localparam int HOLD_DEPTH = ENTITY_WINDOW - 1;
    localparam int CNT_W = $clog2(ENTITY_WINDOW);
    localparam int ADDR_W = $clog2(HOLD_DEPTH);
    localparam int LEN_W = $clog2(ENTITY_WINDOW + 2);

    hesd_state_t state_reg, state_next;

    logic              in_entity_reg, in_entity_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CP_W-1:0]   value_reg, value_next;
    logic              num_reg, num_next;
    logic              hex_reg, hex_next;
    logic              bad_reg, bad_next;
    logic [NAME_COUNT-1:0] cand_reg, cand_next;

    logic              job_dec_reg, job_dec_next;
    logic [CNT_W-1:0]  job_n_reg, job_n_next;
    logic [LEN_W-1:0]  job_len_reg, job_len_next;
    logic [7:0]        job_tail_reg, job_tail_next;
    logic              job_last_reg, job_last_next;
    logic [3:0][7:0]   dec_reg, dec_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              slot_free;
    logic              accept;
    logic              pass_load;
    logic              job_start;
    logic              store;
    logic              emit_load;
    logic              emit_done;
    logic [7:0]        emit_byte;
    logic              rd_en;
    logic [7:0]        rd_data;

    logic [CP_W-1:0]   dig_value;
    logic              dig_bad;
    logic [2:0]        utf_len;
    logic [3:0][7:0]   utf_bytes;

    logic [NAME_COUNT-1:0] name_hit;
    logic [7:0]        name_byte;
    logic              num_ok;

    logic [7:0]        b;
    logic              is_delim;

    assign b         = s_axis_tdata;
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign is_delim  = (b == CH_AMP) || (b == CH_LT) || (b == CH_GT);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    hesd_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_body_ram (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (b),
        .rd_en   (rd_en),
        .rd_addr (pos_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    hesd_digit_unit u_digit (
        .digit_char (b),
        .base_hex   (hex_reg),
        .value      (value_reg),
        .value_next (dig_value),
        .bad        (dig_bad)
    );

    hesd_utf8_enc u_utf8 (
        .cp    (value_reg),
        .len   (utf_len),
        .bytes (utf_bytes)
    );

    // Name match at ';': candidate still alive and body length equals the name length.
    always_comb
    begin
        name_byte = 8'h00;
        for (int k = 0; k < NAME_COUNT; k++)
        begin
            name_hit[k] = cand_reg[k] && (cnt_reg == CNT_W'(name_size(3'(k))));
        end
        for (int k = NAME_COUNT - 1; k >= 0; k--)
        begin
            if (name_hit[k])
            begin
                name_byte = name_value(3'(k));
            end
        end
        num_ok = (cnt_reg != '0) && num_reg && !bad_reg && (value_reg != '0)
                 && (utf_len != 3'd0);
    end

    // Per-byte tracking of the body: numeric accumulator and name candidates.
    always_comb
    begin
        value_next = value_reg;
        num_next   = num_reg;
        hex_next   = hex_reg;
        bad_next   = bad_reg;
        cand_next  = cand_reg;
        if (store)
        begin
            if (cnt_reg == '0)
            begin
                num_next   = (b == CH_HASH);
                hex_next   = 1'b0;
                bad_next   = 1'b0;
                value_next = '0;
                for (int k = 0; k < NAME_COUNT; k++)
                begin
                    cand_next[k] = (name_char(3'(k), 2'd0) == b);
                end
            end
            else
            begin
                for (int k = 0; k < NAME_COUNT; k++)
                begin
                    cand_next[k] = cand_reg[k]
                                   && (cnt_reg < CNT_W'(name_size(3'(k))))
                                   && (name_char(3'(k), cnt_reg[1:0]) == b);
                end
                if (num_reg && !bad_reg)
                begin
                    if ((cnt_reg == CNT_W'(1)) && ((b == CH_X_LO) || (b == CH_X_UP)))
                    begin
                        hex_next = 1'b1;
                    end
                    else if (dig_bad)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        value_next = dig_value;
                    end
                end
            end
        end
    end

    // Input side: decide what an accepted item does and set up an emit job.
    always_comb
    begin
        s_axis_tready  = (state_reg == ST_IDLE) && slot_free;
        pass_load      = 1'b0;
        job_start      = 1'b0;
        store          = 1'b0;
        in_entity_next = in_entity_reg;
        cnt_next       = cnt_reg;
        job_dec_next   = job_dec_reg;
        job_n_next     = job_n_reg;
        job_len_next   = job_len_reg;
        job_tail_next  = job_tail_reg;
        job_last_next  = job_last_reg;
        dec_next       = dec_reg;
        if (accept)
        begin
            job_last_next = s_axis_tlast;
            job_tail_next = b;
            job_dec_next  = 1'b0;
            job_n_next    = cnt_reg;
            if (!in_entity_reg)
            begin
                if (b == CH_AMP)
                begin
                    cnt_next = '0;
                    if (s_axis_tlast)
                    begin
                        // lone '&' at string end: emit it alone
                        job_start    = 1'b1;
                        job_n_next   = '0;
                        job_len_next = LEN_W'(1);
                    end
                    else
                    begin
                        in_entity_next = 1'b1;
                    end
                end
                else
                begin
                    pass_load = 1'b1;
                end
            end
            else if (b == CH_SEMI)
            begin
                job_start      = 1'b1;
                in_entity_next = 1'b0;
                cnt_next       = '0;
                if (|name_hit)
                begin
                    job_dec_next = 1'b1;
                    job_len_next = LEN_W'(1);
                    dec_next     = '0;
                    dec_next[0]  = name_byte;
                end
                else if (num_ok)
                begin
                    job_dec_next = 1'b1;
                    job_len_next = LEN_W'(utf_len);
                    dec_next     = utf_bytes;
                end
                else
                begin
                    job_len_next = LEN_W'(cnt_reg) + LEN_W'(2);
                end
            end
            else if (!is_delim && (cnt_reg < CNT_W'(HOLD_DEPTH)))
            begin
                store    = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (s_axis_tlast)
                begin
                    // string ends inside the body: replay '&' and all held bytes
                    job_start      = 1'b1;
                    job_n_next     = cnt_reg + CNT_W'(1);
                    job_len_next   = LEN_W'(cnt_reg) + LEN_W'(2);
                    in_entity_next = 1'b0;
                    cnt_next       = '0;
                end
            end
            else
            begin
                // delimiter or full body: replay, then the byte itself unless it is an '&' opening a new entity
                job_start = 1'b1;
                cnt_next  = '0;
                if ((b == CH_AMP) && !s_axis_tlast)
                begin
                    job_len_next   = LEN_W'(cnt_reg) + LEN_W'(1);
                    in_entity_next = 1'b1;
                end
                else
                begin
                    job_len_next   = LEN_W'(cnt_reg) + LEN_W'(2);
                    in_entity_next = 1'b0;
                end
            end
        end
    end

    // Emit side: one byte of the current job per free output slot.
    always_comb
    begin
        emit_load = (state_reg == ST_EMIT) && slot_free;
        emit_done = (pos_reg == job_len_reg - LEN_W'(1));
        rd_en     = emit_load && !job_dec_reg && (pos_reg < LEN_W'(job_n_reg));
        pos_next  = pos_reg;
        if (job_start)
        begin
            pos_next = '0;
        end
        else if (emit_load)
        begin
            pos_next = pos_reg + LEN_W'(1);
        end
        if (job_dec_reg)
        begin
            emit_byte = dec_reg[pos_reg[1:0]];
        end
        else if (pos_reg == '0)
        begin
            emit_byte = CH_AMP;
        end
        else if (pos_reg <= LEN_W'(job_n_reg))
        begin
            emit_byte = rd_data;
        end
        else
        begin
            emit_byte = job_tail_reg;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (pass_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = b;
            out_last_next  = s_axis_tlast;
        end
        else if (emit_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = job_last_reg && emit_done;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_start)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load && emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_entity_reg <= 1'b0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_entity_reg <= in_entity_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        num_reg      <= num_next;
        hex_reg      <= hex_next;
        bad_reg      <= bad_next;
        cand_reg     <= cand_next;
        job_dec_reg  <= job_dec_next;
        job_n_reg    <= job_n_next;
        job_len_reg  <= job_len_next;
        job_tail_reg <= job_tail_next;
        job_last_reg <= job_last_next;
        dec_reg      <= dec_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: rtl/hesd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hesd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/hesd_digit_unit.sv
// Shared digit step: value * base + digit with range check against the code point limit.
module hesd_digit_unit (
    input  logic [7:0]                 digit_char,
    input  logic                       base_hex,
    input  logic [hesd_pkg::CP_W-1:0]  value,
    output logic [hesd_pkg::CP_W-1:0]  value_next,
    output logic                       bad
);
    import hesd_pkg::*;

    logic [3:0]      d;
    logic            d_ok;
    logic [CP_W+3:0] prod;
    logic [CP_W+3:0] sum;

    always_comb
    begin
        d    = 4'd0;
        d_ok = 1'b0;
        if (digit_char inside {[8'h30:8'h39]})
        begin
            d    = 4'(digit_char - 8'h30);
            d_ok = 1'b1;
        end
        else if (base_hex && (digit_char inside {[8'h61:8'h66]}))
        begin
            d    = 4'(digit_char - 8'h57);
            d_ok = 1'b1;
        end
        else if (base_hex && (digit_char inside {[8'h41:8'h46]}))
        begin
            d    = 4'(digit_char - 8'h37);
            d_ok = 1'b1;
        end
    end

    always_comb
    begin
        if (base_hex)
        begin
            prod = {value, 4'b0000};
        end
        else
        begin
            prod = {1'b0, value, 3'b000} + {3'b000, value, 1'b0};
        end
        sum        = prod + (CP_W+4)'(d);
        bad        = !d_ok || (sum > (CP_W+4)'(CP_MAX));
        value_next = sum[CP_W-1:0];
    end

endmodule

// File: rtl/hesd_utf8_enc.sv
// UTF-8 encoder for one code point; a length of zero marks a surrogate or out-of-range value.
module hesd_utf8_enc (
    input  logic [hesd_pkg::CP_W-1:0] cp,
    output logic [2:0]                len,
    output logic [3:0][7:0]           bytes
);
    import hesd_pkg::*;

    always_comb
    begin
        bytes = '0;
        if (cp <= CP_1B_MAX)
        begin
            len      = 3'd1;
            bytes[0] = cp[7:0];
        end
        else if (cp <= CP_2B_MAX)
        begin
            len      = 3'd2;
            bytes[0] = {3'b110, cp[10:6]};
            bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp >= SURR_LO && cp <= SURR_HI)
        begin
            len = 3'd0;
        end
        else if (cp <= CP_3B_MAX)
        begin
            len      = 3'd3;
            bytes[0] = {4'b1110, cp[15:12]};
            bytes[1] = {2'b10, cp[11:6]};
            bytes[2] = {2'b10, cp[5:0]};
        end
        else if (cp <= CP_MAX)
        begin
            len      = 3'd4;
            bytes[0] = {5'b11110, cp[20:18]};
            bytes[1] = {2'b10, cp[17:12]};
            bytes[2] = {2'b10, cp[11:6]};
            bytes[3] = {2'b10, cp[5:0]};
        end
        else
        begin
            len = 3'd0;
        end
    end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the HTML entity stream decoder core.
`timescale 1ns / 100ps

module tb_top;

    import hesd_pkg::*;

    localparam int HOLD_DEPTH      = ENTITY_WINDOW_DEF - 1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 3000;
    localparam int TAIL_CYCLES     = 24;

    // Predicts the decoded byte stream and keeps the bytes still owed by the core.
    class entity_scoreboard;
        logic [7:0]  held_body [HOLD_DEPTH];
        int unsigned held_count;
        bit          in_entity;
        logic [7:0]  decoded [4];
        logic [7:0]  step_bytes [$];
        logic [8:0]  owed_bytes [$];    // {last, byte}
        string       entity_names [NAME_COUNT];
        logic [7:0]  entity_chars [NAME_COUNT];
        int          mismatches;
        int          bytes_taken;
        int          bytes_checked;
        int          entities_replaced;
        int          entities_literal;

        function new();
            entity_names = '{"lt", "gt", "amp", "quot", "apos", "nbsp"};
            entity_chars = '{CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS, CH_SPACE};
            held_count = 0;
            in_entity = 1'b0;
            mismatches = 0;
            bytes_taken = 0;
            bytes_checked = 0;
            entities_replaced = 0;
            entities_literal = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        function int pending();
            return owed_bytes.size();
        endfunction

        function void flush_held();
            int unsigned i;
            step_bytes.push_back(CH_AMP);
            for (i = 0; i < held_count; i++)
                step_bytes.push_back(held_body[i]);
            entities_literal++;
        endfunction

        function int unsigned digit_of(logic [7:0] c, int unsigned base);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (base == 16 && c >= "a" && c <= "f")
                return 10 + c - "a";
            if (base == 16 && c >= "A" && c <= "F")
                return 10 + c - "A";
            return 99;
        endfunction

        function int pack_utf8(int unsigned cp);
            if (cp <= CP_1B_MAX)
            begin
                decoded[0] = cp[7:0];
                return 1;
            end
            if (cp <= CP_2B_MAX)
            begin
                decoded[0] = 8'hC0 | 8'(cp >> 6);
                decoded[1] = 8'h80 | 8'(cp & 'h3F);
                return 2;
            end
            if (cp >= SURR_LO && cp <= SURR_HI)
                return 0;
            if (cp <= CP_3B_MAX)
            begin
                decoded[0] = 8'hE0 | 8'(cp >> 12);
                decoded[1] = 8'h80 | 8'((cp >> 6) & 'h3F);
                decoded[2] = 8'h80 | 8'(cp & 'h3F);
                return 3;
            end
            if (cp <= CP_MAX)
            begin
                decoded[0] = 8'hF0 | 8'(cp >> 18);
                decoded[1] = 8'h80 | 8'((cp >> 12) & 'h3F);
                decoded[2] = 8'h80 | 8'((cp >> 6) & 'h3F);
                decoded[3] = 8'h80 | 8'(cp & 'h3F);
                return 4;
            end
            return 0;
        endfunction

        // Number of bytes the held body decodes to; zero rejects it.
        function int decode_held();
            int unsigned n, base, start, value, d, i;
            int          k;
            bit          hit;
            n = held_count;
            if (n == 0)
                return 0;
            if (held_body[0] == CH_HASH)
            begin
                base = 10;
                start = 1;
                value = 0;
                if (n < 2)
                    return 0;
                if (n >= 3 && (held_body[1] == CH_X_LO || held_body[1] == CH_X_UP))
                begin
                    base = 16;
                    start = 2;
                end
                for (i = start; i < n; i++)
                begin
                    d = digit_of(held_body[i], base);
                    if (d >= base)
                        return 0;
                    if (value > (CP_MAX - d) / base)
                        return 0;
                    value = value * base + d;
                end
                if (value == 0)
                    return 0;
                return pack_utf8(value);
            end
            for (k = 0; k < NAME_COUNT; k++)
            begin
                if (entity_names[k].len() == n)
                begin
                    hit = 1'b1;
                    for (i = 0; i < n; i++)
                        if (held_body[i] != entity_names[k][i])
                            hit = 1'b0;
                    if (hit)
                    begin
                        decoded[0] = entity_chars[k];
                        return 1;
                    end
                end
            end
            return 0;
        endfunction

        // Advance the predicted state by one accepted text byte.
        function void note_input(logic [7:0] b, logic last);
            int k, i;
            step_bytes.delete();
            bytes_taken++;
            if (!in_entity)
            begin
                if (b == CH_AMP)
                begin
                    in_entity = 1'b1;
                    held_count = 0;
                end
                else
                    step_bytes.push_back(b);
            end
            else if (b == CH_SEMI)
            begin
                k = decode_held();
                if (k > 0)
                begin
                    for (i = 0; i < k; i++)
                        step_bytes.push_back(decoded[i]);
                    entities_replaced++;
                end
                else
                begin
                    flush_held();
                    step_bytes.push_back(CH_SEMI);
                end
                in_entity = 1'b0;
                held_count = 0;
            end
            else if (b != CH_AMP && b != CH_LT && b != CH_GT && held_count < HOLD_DEPTH)
            begin
                held_body[held_count] = b;
                held_count++;
            end
            else
            begin
                flush_held();
                held_count = 0;
                if (b == CH_AMP)
                    in_entity = 1'b1;
                else
                begin
                    in_entity = 1'b0;
                    step_bytes.push_back(b);
                end
            end
            if (last)
            begin
                if (in_entity)
                    flush_held();
                in_entity = 1'b0;
                held_count = 0;
            end
            for (i = 0; i < step_bytes.size(); i++)
                owed_bytes.push_back({last && (i == step_bytes.size() - 1), step_bytes[i]});
        endfunction

        task check_result(logic [7:0] b, logic last);
            logic [8:0] want;
            bytes_checked++;
            if (owed_bytes.size() == 0)
            begin
                report($sformatf("output byte %02h last=%0b with nothing owed", b, last));
                return;
            end
            want = owed_bytes.pop_front();
            if (b !== want[7:0])
                report($sformatf("output byte %02h, predicted %02h", b, want[7:0]));
            if (last !== want[8])
                report($sformatf("out_last %0b on byte %02h, predicted %0b", last, b, want[8]));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    entity_scoreboard sb;
    logic [7:0] run_q [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int strings_sent = 0;

    html_entity_stream_decoder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random back-pressure, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // End the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d cycles without a handshake", quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_input(b, last);
    endtask

    task automatic send_str(input string s, input bit last);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], last && (i == s.len() - 1));
    endtask

    // Drop valid and hold the input until the core has delivered everything owed.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] any_letter();
        return 8'($urandom_range("a", "z"));
    endfunction

    function automatic logic [7:0] mixed_byte();
        case ($urandom_range(0, 9))
            0:       return CH_HASH;
            1:       return CH_X_LO;
            2:       return CH_X_UP;
            3:       return CH_SEMI;
            4:       return CH_AMP;
            5:       return CH_LT;
            6:       return CH_GT;
            7:       return 8'($urandom_range("0", "9"));
            8:       return any_letter();
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            run_q.push_back(s[i]);
    endfunction

    function automatic void add_plain();
        repeat ($urandom_range(1, 6))
            run_q.push_back(8'($urandom_range(1, 255)));
    endfunction

    // A named entity, now and then with one letter in the wrong case.
    function automatic void add_named();
        string s;
        int    i;
        s = sb.entity_names[$urandom_range(0, NAME_COUNT - 1)];
        if ($urandom_range(0, 5) == 0)
        begin
            i = $urandom_range(0, s.len() - 1);
            s[i] = s[i] ^ 8'h20;
        end
        add_text({"&", s, ";"});
    endfunction

    // A decimal or hex reference spread over every UTF-8 length and the rejected ranges.
    function automatic void add_numeric();
        int unsigned cp;
        string       digits;
        bit          hex;
        int          i;
        hex = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 8))
            0:       cp = $urandom_range(1, 'h7F);
            1:       cp = $urandom_range('h80, 'h7FF);
            2:       cp = $urandom_range('h800, 'hFFFF);
            3:       cp = $urandom_range('h10000, 'h10FFFF);
            4:       cp = $urandom_range(SURR_LO, SURR_HI);
            5:       cp = 0;
            6:       cp = $urandom_range('h110000, 'h1FFFFF);
            7:       cp = $urandom_range(0, 1) ? 'h10FFFF : 'h110000;
            default: cp = $urandom;
        endcase
        digits = hex ? $sformatf("%0h", cp) : $sformatf("%0d", cp);
        if (hex)
            for (i = 0; i < digits.len(); i++)
                if (digits[i] >= "a" && $urandom_range(0, 1))
                    digits[i] = digits[i] - 8'd32;
        repeat ($urandom_range(0, 2))
            digits = {"0", digits};
        if (hex && $urandom_range(0, 1))
            add_text({"&#X", digits});
        else if (hex)
            add_text({"&#x", digits});
        else
            add_text({"&#", digits});
        case ($urandom_range(0, 9))
            0:
                ;   // leave the body open, the next segment runs into it
            1:
            begin
                run_q.push_back(8'($urandom_range("g", "z")));
                run_q.push_back(CH_SEMI);
            end
            default:
                run_q.push_back(CH_SEMI);
        endcase
    endfunction

    function automatic void add_broken();
        case ($urandom_range(0, 3))
            0:
            begin
                // full body, then either a terminator or an overflowing byte
                run_q.push_back(CH_AMP);
                repeat (HOLD_DEPTH)
                    run_q.push_back(any_letter());
                run_q.push_back($urandom_range(0, 1) ? CH_SEMI : 8'($urandom_range(1, 255)));
            end
            1:
            begin
                run_q.push_back(CH_AMP);
                repeat ($urandom_range(0, 4))
                    run_q.push_back(any_letter());
                case ($urandom_range(0, 2))
                    0:       run_q.push_back(CH_LT);
                    1:       run_q.push_back(CH_GT);
                    default: run_q.push_back(CH_AMP);
                endcase
            end
            2:
            begin
                run_q.push_back(CH_AMP);
                repeat ($urandom_range(0, 16))
                    run_q.push_back(mixed_byte());
                run_q.push_back(CH_SEMI);
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       add_text("&#;");
                    1:       add_text("&#x;");
                    default: add_text("&;");
                endcase
            end
        endcase
    endfunction

    task automatic send_random_string();
        int i;
        run_q.delete();
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_plain();
                3, 4, 5: add_named();
                6, 7:    add_numeric();
                default: add_broken();
            endcase
        end
        // sometimes end the string in the middle of an entity
        if ($urandom_range(0, 5) == 0)
        begin
            run_q.push_back(CH_AMP);
            repeat ($urandom_range(0, 4))
                run_q.push_back(any_letter());
        end
        for (i = 0; i < run_q.size(); i++)
            send_item(run_q[i], i == run_q.size() - 1);
        strings_sent++;
    endtask

    task automatic run_phase(input int n_items, input int s_pct, input int r_pct);
        int start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = sb.bytes_taken;
        while (sb.bytes_taken - start < n_items)
            send_random_string();
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 64;

        // Directed: byte extremes, a name, the top code point, delimiters, a
        // rejected zero and a string ending inside an entity.
        send_item(8'h01, 1'b0);
        send_item(8'hFF, 1'b0);
        send_str("&lt;", 1'b0);
        send_str("&#x10FFFF;", 1'b0);
        send_str("&a&b>", 1'b0);
        send_str("&#0;", 1'b0);
        send_str("&q", 1'b1);
        strings_sent++;

        run_phase(50, 24, 64);
        hold_trigger++;     // output side stalls while input keeps coming
        run_phase(70, 24, 64);
        wait_drained();
        run_phase(110, 64, 24);
        run_phase(120, 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d input bytes in %0d strings; checked %0d output bytes.",
                 sb.bytes_taken, strings_sent, sb.bytes_checked);
        $display("Entities replaced: %0d, passed through literally: %0d, mismatches: %0d.",
                 sb.entities_replaced, sb.entities_literal, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
